// ----- rtl/cssm_pkg.sv -----
// Shared types, character codes and byte-class functions for the CSS minifier.
`timescale 1ns / 1ps

package cssm_pkg;

    localparam int WIN_LEN  = 7;
    localparam int LA_LEN   = WIN_LEN - 1;
    localparam int FILL_W   = 3;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int QCNT_W   = 3;
    localparam int OBUF_LEN = 4;
    localparam int OCNT_W   = 3;
    localparam int SKIP_W   = 3;

    typedef logic [7:0] t_byte;

    // one window position to scan, with the bytes that follow it (zero past the text end)
    typedef struct packed {
        logic                    is_end;
        t_byte                   ch;
        t_byte [LA_LEN-1:0]      la;
    } t_op;

    typedef struct packed {
        t_byte out_byte;
        logic  has_byte;
        logic  out_last;
    } t_res;

    localparam t_byte CH_NUL     = 8'h00;
    localparam t_byte CH_SPACE   = 8'h20;
    localparam t_byte CH_DQUOTE  = 8'h22;
    localparam t_byte CH_HASH    = 8'h23;
    localparam t_byte CH_SQUOTE  = 8'h27;
    localparam t_byte CH_LPAREN  = 8'h28;
    localparam t_byte CH_STAR    = 8'h2A;
    localparam t_byte CH_PLUS    = 8'h2B;
    localparam t_byte CH_COMMA   = 8'h2C;
    localparam t_byte CH_DOT     = 8'h2E;
    localparam t_byte CH_SLASH   = 8'h2F;
    localparam t_byte CH_ZERO    = 8'h30;
    localparam t_byte CH_NINE    = 8'h39;
    localparam t_byte CH_COLON   = 8'h3A;
    localparam t_byte CH_SEMI    = 8'h3B;
    localparam t_byte CH_GT      = 8'h3E;
    localparam t_byte CH_UA      = 8'h41;
    localparam t_byte CH_UF      = 8'h46;
    localparam t_byte CH_UZ      = 8'h5A;
    localparam t_byte CH_LBRACK  = 8'h5B;
    localparam t_byte CH_BSLASH  = 8'h5C;
    localparam t_byte CH_LA      = 8'h61;
    localparam t_byte CH_LF      = 8'h66;
    localparam t_byte CH_LZ      = 8'h7A;
    localparam t_byte CH_LBRACE  = 8'h7B;
    localparam t_byte CH_RBRACE  = 8'h7D;
    localparam t_byte CH_TILDE   = 8'h7E;
    localparam t_byte CH_TAB     = 8'h09;
    localparam t_byte CH_CR      = 8'h0D;
    localparam t_byte CASE_DELTA = 8'h20;

    function automatic logic is_digit(input t_byte c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_upper(input t_byte c);
        return (c >= CH_UA) && (c <= CH_UZ);
    endfunction

    function automatic logic is_alpha(input t_byte c);
        return ((c >= CH_LA) && (c <= CH_LZ)) || is_upper(c);
    endfunction

    function automatic logic is_alnum(input t_byte c);
        return is_digit(c) || is_alpha(c);
    endfunction

    function automatic logic is_space(input t_byte c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_hex(input t_byte c);
        return is_digit(c) || ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
    endfunction

    function automatic t_byte to_lower(input t_byte c);
        return is_upper(c) ? t_byte'(c + CASE_DELTA) : c;
    endfunction

    function automatic logic no_space_after(input t_byte c);
        return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_SEMI) || (c == CH_COLON) ||
               (c == CH_COMMA) || (c == CH_GT) || (c == CH_PLUS) || (c == CH_TILDE) ||
               (c == CH_LPAREN) || (c == CH_LBRACK);
    endfunction

endpackage

// ----- rtl/cssm_in_if.sv -----
// Input channel: one raw text byte per item, with the end-of-text mark.
`timescale 1ns / 1ps

interface cssm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ----- rtl/cssm_out_if.sv -----
// Output channel: one minified byte or the end marker per item.
`timescale 1ns / 1ps

interface cssm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output has_byte, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input has_byte, input out_last,
                    output ready);
endinterface

// ----- rtl/cssm_front.sv -----
// Front end: lookahead window, end-of-text flush, and scan op generation.
`timescale 1ns / 1ps

module cssm_front
    import cssm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    cssm_in_if.sink      i_in,
    input  logic         i_full,
    output logic         o_push,
    output t_op          o_op
);

    t_byte              r_win [WIN_LEN];
    t_byte              n_win [WIN_LEN];
    logic [FILL_W-1:0]  r_fill;
    logic [FILL_W-1:0]  n_fill;
    logic               r_flush;
    logic [FILL_W-1:0]  r_pos;
    logic               accept;
    logic               flush_push;

    assign i_in.ready = !r_flush && !i_full;
    assign accept     = i_in.valid && i_in.ready;
    assign flush_push = r_flush && !i_full;

    always_comb begin
        n_win = r_win;
        if (r_fill == FILL_W'(WIN_LEN)) begin
            for (int k = 0; k < WIN_LEN - 1; k++) begin
                n_win[k] = r_win[k+1];
            end
            n_win[WIN_LEN-1] = i_in.in_byte;
            n_fill = r_fill;
        end else begin
            n_win[r_fill] = i_in.in_byte;
            n_fill = r_fill + FILL_W'(1);
        end
    end

    always_comb begin
        logic [FILL_W:0] j;
        j      = '0;
        o_push = 1'b0;
        o_op   = '0;
        if (accept) begin
            // full window: the oldest byte leaves with six bytes of lookahead
            if (n_fill == FILL_W'(WIN_LEN)) begin
                o_push = 1'b1;
                o_op.ch = n_win[0];
                for (int k = 0; k < LA_LEN; k++) begin
                    o_op.la[k] = n_win[k+1];
                end
            end
        end else if (flush_push) begin
            o_push = 1'b1;
            if (r_pos < r_fill) begin
                o_op.ch = r_win[r_pos];
                for (int k = 0; k < LA_LEN; k++) begin
                    j = {1'b0, r_pos} + (FILL_W+1)'(k + 1);
                    if (j < {1'b0, r_fill}) begin
                        o_op.la[k] = r_win[j[FILL_W-1:0]];
                    end
                end
            end else begin
                o_op.is_end = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_flush <= 1'b0;
            r_pos   <= '0;
        end else if (accept) begin
            r_fill <= n_fill;
            if (i_in.in_last) begin
                r_flush <= 1'b1;
                r_pos   <= (n_fill == FILL_W'(WIN_LEN)) ? FILL_W'(1) : '0;
            end
        end else if (flush_push) begin
            if (r_pos < r_fill) begin
                r_pos <= r_pos + FILL_W'(1);
            end else begin
                r_flush <= 1'b0;
                r_fill  <= '0;
                r_pos   <= '0;
            end
        end
    end

endmodule

// ----- rtl/cssm_fifo.sv -----
// Short op queue between the front end and the scanner.
`timescale 1ns / 1ps

module cssm_fifo
    import cssm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_op   i_op,
    output logic  o_full,
    output logic  o_valid,
    output t_op   o_op,
    input  logic  i_pop
);

    t_op               r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("op queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("op queue read while empty");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("op queue count out of range");
`endif

endmodule

// ----- rtl/cssm_back.sv -----
// Scanner: applies comment, string, whitespace, zero, hex-color and letter-case rules to each op.
`timescale 1ns / 1ps

module cssm_back
    import cssm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_op_valid,
    input  t_op          i_op,
    output logic         o_pop,
    cssm_out_if.source   o_out
);

    logic [SKIP_W-1:0] r_skip, n_skip;
    logic              r_comment, n_comment;
    logic              r_str, n_str;
    t_byte             r_qk, n_qk;
    t_byte             r_pout, n_pout;
    t_byte             r_praw, n_praw;
    logic              r_pend, n_pend;
    logic              r_val, n_val;

    t_res              r_buf [OBUF_LEN];
    t_res              n_res [OBUF_LEN];
    logic [OCNT_W-1:0] r_cnt, n_rcnt;

    logic              take;
    logic              room;

    function automatic t_res byte_res(input t_byte b);
        t_res r;
        r.out_byte = b;
        r.has_byte = 1'b1;
        r.out_last = 1'b0;
        return r;
    endfunction

    assign o_out.valid    = (r_cnt != '0);
    assign o_out.out_byte = r_buf[0].out_byte;
    assign o_out.has_byte = r_buf[0].has_byte;
    assign o_out.out_last = r_buf[0].out_last;

    assign take  = o_out.valid && o_out.ready;
    assign room  = (r_cnt == '0) || ((r_cnt == OCNT_W'(1)) && take);
    assign o_pop = i_op_valid && room;

    always_comb begin
        t_byte c;
        t_byte nx;
        t_byte ch;
        logic  vnew;
        logic  hex_ok;
        c         = i_op.ch;
        nx        = i_op.la[0];
        ch        = c;
        vnew      = r_val;
        hex_ok    = 1'b0;
        n_skip    = r_skip;
        n_comment = r_comment;
        n_str     = r_str;
        n_qk      = r_qk;
        n_pout    = r_pout;
        n_praw    = r_praw;
        n_pend    = r_pend;
        n_val     = r_val;
        n_rcnt    = '0;
        for (int k = 0; k < OBUF_LEN; k++) begin
            n_res[k] = '0;
        end

        if (i_op.is_end) begin
            n_res[0].out_last = 1'b1;
            n_rcnt    = OCNT_W'(1);
            n_skip    = '0;
            n_comment = 1'b0;
            n_str     = 1'b0;
            n_qk      = CH_NUL;
            n_pout    = CH_NUL;
            n_praw    = CH_NUL;
            n_pend    = 1'b0;
            n_val     = 1'b0;
        end else begin
            n_praw = c;
            if (r_skip != '0) begin
                n_skip = r_skip - SKIP_W'(1);
            end else if (!r_str && c == CH_SLASH && nx == CH_STAR) begin
                n_comment = 1'b1;
                n_skip    = SKIP_W'(1);
            end else if (r_comment && c == CH_STAR && nx == CH_SLASH) begin
                n_comment = 1'b0;
                n_skip    = SKIP_W'(1);
            end else if (!r_comment) begin
                if (!r_str && (c == CH_DQUOTE || c == CH_SQUOTE)) begin
                    n_str    = 1'b1;
                    n_qk     = c;
                    n_res[0] = byte_res(c);
                    n_rcnt   = OCNT_W'(1);
                    n_pout   = c;
                end else if (r_str) begin
                    // an escaped quote does not close the string
                    if (c == r_qk && r_praw != CH_BSLASH) begin
                        n_str = 1'b0;
                    end
                    n_res[0] = byte_res(c);
                    n_rcnt   = OCNT_W'(1);
                    n_pout   = c;
                end else begin
                    if (c == CH_COLON) begin
                        vnew = 1'b1;
                    end else if (c == CH_SEMI || c == CH_LBRACE || c == CH_RBRACE) begin
                        vnew = 1'b0;
                    end
                    n_val = vnew;

                    hex_ok = 1'b1;
                    for (int k = 0; k < LA_LEN; k++) begin
                        if (!is_hex(i_op.la[k])) begin
                            hex_ok = 1'b0;
                        end
                    end
                    hex_ok = hex_ok &&
                             (to_lower(i_op.la[0]) == to_lower(i_op.la[1])) &&
                             (to_lower(i_op.la[2]) == to_lower(i_op.la[3])) &&
                             (to_lower(i_op.la[4]) == to_lower(i_op.la[5]));

                    ch = (is_alpha(c) && !vnew) ? to_lower(c) : c;

                    if (is_space(c)) begin
                        if (r_pout != CH_NUL && !no_space_after(r_pout)) begin
                            n_pend = 1'b1;
                        end
                    end else if (c == CH_ZERO && nx == CH_DOT && !is_digit(r_pout)) begin
                        n_res[0] = byte_res(CH_DOT);
                        n_rcnt   = OCNT_W'(1);
                        n_pout   = CH_DOT;
                        n_pend   = 1'b0;
                        n_skip   = SKIP_W'(1);
                    end else if (c == CH_HASH && vnew) begin
                        n_res[0] = byte_res(CH_HASH);
                        n_rcnt   = OCNT_W'(1);
                        n_pout   = CH_HASH;
                        if (hex_ok) begin
                            n_res[1] = byte_res(to_lower(i_op.la[0]));
                            n_res[2] = byte_res(to_lower(i_op.la[2]));
                            n_res[3] = byte_res(to_lower(i_op.la[4]));
                            n_rcnt   = OCNT_W'(OBUF_LEN);
                            n_pout   = i_op.la[5];
                            n_pend   = 1'b0;
                            n_skip   = SKIP_W'(LA_LEN);
                        end
                    end else begin
                        if (r_pend && is_alnum(c) && is_alnum(r_pout)) begin
                            n_res[0] = byte_res(CH_SPACE);
                            n_res[1] = byte_res(ch);
                            n_rcnt   = OCNT_W'(2);
                        end else begin
                            n_res[0] = byte_res(ch);
                            n_rcnt   = OCNT_W'(1);
                        end
                        n_pend = 1'b0;
                        n_pout = c;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_buf <= n_res;
        end else if (take) begin
            for (int k = 0; k < OBUF_LEN - 1; k++) begin
                r_buf[k] <= r_buf[k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_skip    <= '0;
            r_comment <= 1'b0;
            r_str     <= 1'b0;
            r_qk      <= CH_NUL;
            r_pout    <= CH_NUL;
            r_praw    <= CH_NUL;
            r_pend    <= 1'b0;
            r_val     <= 1'b0;
        end else if (o_pop) begin
            r_cnt     <= n_rcnt;
            r_skip    <= n_skip;
            r_comment <= n_comment;
            r_str     <= n_str;
            r_qk      <= n_qk;
            r_pout    <= n_pout;
            r_praw    <= n_praw;
            r_pend    <= n_pend;
            r_val     <= n_val;
        end else if (take) begin
            r_cnt <= r_cnt - OCNT_W'(1);
        end
    end

`ifndef SYNTHESIS
    a_skip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip <= SKIP_W'(LA_LEN))
        else $error("skip count beyond a hex color span");

    a_buf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= OCNT_W'(OBUF_LEN))
        else $error("result buffer count out of range");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_op.is_end) |=> (o_out.valid && o_out.out_last && !o_out.has_byte))
        else $error("end marker not presented after end op");
`endif

endmodule

// ----- rtl/css_minify_stream.sv -----
// Top level of the streaming CSS minifier.
// Takes one CSS text byte per item with a last mark and gives the minified text one byte per
// item, then a bare end marker (has_byte low, out_last high). Output lags input by a
// seven-byte lookahead window: no byte leaves until seven bytes are in, and the last byte
// flushes the rest. An input byte is taken every cycle while the op queue has room; after
// the last byte the input stalls, also while the op queue is full, as the front end walks
// the rest of the window and queues the end marker. The scanner handles one window position
// per cycle while the output keeps up, and takes no new position until every result byte of
// the last one has left (a restored space gives two bytes, a short hex color four), so the
// output carries at most one byte per cycle, bounded by the single output port.
`timescale 1ns / 1ps

module css_minify_stream
    import cssm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    cssm_in_if.sink       i_in_ch,
    cssm_out_if.source    o_out_ch
);

    logic q_push;
    t_op  q_in;
    logic q_full;
    logic q_valid;
    t_op  q_out;
    logic q_pop;

    cssm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in_ch),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_op    (q_in)
    );

    cssm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (q_out),
        .i_pop   (q_pop)
    );

    cssm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (q_valid),
        .i_op       (q_out),
        .o_pop      (q_pop),
        .o_out      (o_out_ch)
    );

endmodule
